// ===== rtl/escape_sequence_expander_core_defines.svh =====
// ----------------------------------------------------------------------------
// escape sequence expander assertion macros
// shared helpers for the concurrent checks in the rtl
// ----------------------------------------------------------------------------
`ifndef ESCAPE_SEQUENCE_EXPANDER_CORE_DEFINES_SVH
`define ESCAPE_SEQUENCE_EXPANDER_CORE_DEFINES_SVH

// check sampled on the rising edge, masked while reset is asserted
`define ESX_ASSERT(label, clk_s, rst_s, prop, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);

// check sampled on the rising edge, also active during reset
`define ESX_ASSERT_ALWAYS(label, clk_s, prop, msg) \
    label: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

// ===== rtl/esx_pkg.sv =====
// ----------------------------------------------------------------------------
// esx_pkg
// types and constants shared by the escape sequence expander modules
// ----------------------------------------------------------------------------
`default_nettype none

package esx_pkg;

    // parser modes
    localparam logic [2:0] MODE_IDLE = 3'd0;
    localparam logic [2:0] MODE_ESC  = 3'd1;
    localparam logic [2:0] MODE_HEX1 = 3'd2;
    localparam logic [2:0] MODE_HEX2 = 3'd3;
    localparam logic [2:0] MODE_OCT1 = 3'd4;
    localparam logic [2:0] MODE_OCT2 = 3'd5;
    localparam logic [2:0] MODE_DROP = 3'd6;

    // error codes
    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_LONE_BS = 3'd1;
    localparam logic [2:0] ERR_X_END   = 3'd2;
    localparam logic [2:0] ERR_BAD_HEX = 3'd3;
    localparam logic [2:0] ERR_OCT_OVF = 3'd4;
    localparam logic [2:0] ERR_UNKNOWN = 3'd5;

    // characters of interest
    localparam logic [7:0] CH_BACKSLASH = 8'h5c;
    localparam logic [7:0] CH_X         = 8'h78;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_SEVEN     = 8'h37;
    localparam logic [7:0] BYTE_MAX     = 8'hff;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] error_code;
        logic       string_done;
    } result_t;

    // up to two results caused by one character
    typedef struct packed {
        logic [1:0] cnt;
        result_t    r0;
        result_t    r1;
    } parse_out_t;

endpackage

`default_nettype wire

// ===== rtl/esx_parser.sv =====
// ----------------------------------------------------------------------------
// esx_parser
// escape parser state and the per-character decode into zero to two results
// ----------------------------------------------------------------------------
`default_nettype none

`include "escape_sequence_expander_core_defines.svh"

module esx_parser
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                accept,
    input  wire logic [7:0]          char_in,
    input  wire logic                last_char,
    output esx_pkg::parse_out_t      po
);
    import esx_pkg::*;

    logic [2:0] mode_reg;
    logic [2:0] mode_next;
    logic [8:0] pv_reg;
    logic [8:0] pv_next;

    logic       hex_ok;
    logic [3:0] hex_d;
    logic       oct_ok;
    logic [2:0] oct_d;
    logic       named_ok;
    logic [7:0] named_v;
    logic [8:0] oct_v;

    // what a character does when seen outside any escape
    logic       idle_cnt;
    result_t    idle_res;
    logic [2:0] idle_mode;

    parse_out_t res;

    always_comb
    begin
        hex_ok = 1'b1;
        hex_d  = 4'd0;
        if (char_in inside {[8'h30:8'h39]})
            hex_d = 4'(char_in - 8'h30);
        else if (char_in inside {[8'h61:8'h66]})
            hex_d = 4'(char_in - 8'h57);
        else if (char_in inside {[8'h41:8'h46]})
            hex_d = 4'(char_in - 8'h37);
        else
            hex_ok = 1'b0;
    end

    assign oct_ok = (char_in >= CH_ZERO) && (char_in <= CH_SEVEN);
    assign oct_d  = char_in[2:0];
    assign oct_v  = {pv_reg[5:0], oct_d};

    always_comb
    begin
        named_ok = 1'b1;
        case (char_in)
            8'h61:   named_v = 8'h07;
            8'h62:   named_v = 8'h08;
            8'h66:   named_v = 8'h0c;
            8'h6e:   named_v = 8'h0a;
            8'h72:   named_v = 8'h0d;
            8'h74:   named_v = 8'h09;
            8'h76:   named_v = 8'h0b;
            8'h5c:   named_v = 8'h5c;
            8'h3f:   named_v = 8'h3f;
            8'h27:   named_v = 8'h27;
            8'h22:   named_v = 8'h22;
            default:
            begin
                named_ok = 1'b0;
                named_v  = 8'h00;
            end
        endcase
    end

    always_comb
    begin
        if (char_in != CH_BACKSLASH)
        begin
            idle_cnt  = 1'b1;
            idle_res  = '{out_byte: char_in, error_code: ERR_NONE, string_done: last_char};
            idle_mode = MODE_IDLE;
        end
        else if (last_char)
        begin
            idle_cnt  = 1'b1;
            idle_res  = '{out_byte: 8'h00, error_code: ERR_LONE_BS, string_done: 1'b1};
            idle_mode = MODE_IDLE;
        end
        else
        begin
            idle_cnt  = 1'b0;
            idle_res  = '{out_byte: 8'h00, error_code: ERR_NONE, string_done: 1'b0};
            idle_mode = MODE_ESC;
        end
    end

    always_comb
    begin
        res       = '0;
        mode_next = MODE_IDLE;
        pv_next   = '0;
        case (mode_reg)
            MODE_ESC:
            begin
                if (char_in == CH_X)
                begin
                    if (last_char)
                    begin
                        res.cnt = 2'd1;
                        res.r0  = '{out_byte: 8'h00, error_code: ERR_X_END, string_done: 1'b1};
                    end
                    else
                        mode_next = MODE_HEX1;
                end
                else if (oct_ok)
                begin
                    if (last_char)
                    begin
                        res.cnt = 2'd1;
                        res.r0  = '{out_byte: {5'd0, oct_d}, error_code: ERR_NONE,
                                    string_done: 1'b1};
                    end
                    else
                    begin
                        mode_next = MODE_OCT1;
                        pv_next   = {6'd0, oct_d};
                    end
                end
                else if (named_ok)
                begin
                    res.cnt = 2'd1;
                    res.r0  = '{out_byte: named_v, error_code: ERR_NONE,
                                string_done: last_char};
                end
                else
                begin
                    res.cnt   = 2'd1;
                    res.r0    = '{out_byte: 8'h00, error_code: ERR_UNKNOWN, string_done: 1'b1};
                    mode_next = last_char ? MODE_IDLE : MODE_DROP;
                end
            end
            MODE_HEX1:
            begin
                if (!hex_ok)
                begin
                    res.cnt   = 2'd1;
                    res.r0    = '{out_byte: 8'h00, error_code: ERR_BAD_HEX, string_done: 1'b1};
                    mode_next = last_char ? MODE_IDLE : MODE_DROP;
                end
                else if (last_char)
                begin
                    res.cnt = 2'd1;
                    res.r0  = '{out_byte: {4'd0, hex_d}, error_code: ERR_NONE,
                                string_done: 1'b1};
                end
                else
                begin
                    mode_next = MODE_HEX2;
                    pv_next   = {5'd0, hex_d};
                end
            end
            MODE_HEX2:
            begin
                if (hex_ok)
                begin
                    res.cnt = 2'd1;
                    res.r0  = '{out_byte: {pv_reg[3:0], hex_d}, error_code: ERR_NONE,
                                string_done: last_char};
                end
                else
                begin
                    // flush the pending digit, then treat the character fresh
                    res.cnt   = {1'b0, idle_cnt} + 2'd1;
                    res.r0    = '{out_byte: pv_reg[7:0], error_code: ERR_NONE,
                                  string_done: 1'b0};
                    res.r1    = idle_res;
                    mode_next = idle_mode;
                end
            end
            MODE_OCT1, MODE_OCT2:
            begin
                if (!oct_ok)
                begin
                    res.cnt   = {1'b0, idle_cnt} + 2'd1;
                    res.r0    = '{out_byte: pv_reg[7:0], error_code: ERR_NONE,
                                  string_done: 1'b0};
                    res.r1    = idle_res;
                    mode_next = idle_mode;
                end
                else if (mode_reg == MODE_OCT2)
                begin
                    res.cnt = 2'd1;
                    if (oct_v > {1'b0, BYTE_MAX})
                    begin
                        res.r0    = '{out_byte: 8'h00, error_code: ERR_OCT_OVF,
                                      string_done: 1'b1};
                        mode_next = last_char ? MODE_IDLE : MODE_DROP;
                    end
                    else
                        res.r0 = '{out_byte: oct_v[7:0], error_code: ERR_NONE,
                                   string_done: last_char};
                end
                else if (last_char)
                begin
                    res.cnt = 2'd1;
                    res.r0  = '{out_byte: oct_v[7:0], error_code: ERR_NONE,
                                string_done: 1'b1};
                end
                else
                begin
                    mode_next = MODE_OCT2;
                    pv_next   = oct_v;
                end
            end
            MODE_DROP:
            begin
                mode_next = last_char ? MODE_IDLE : MODE_DROP;
            end
            default:
            begin
                res.cnt   = {1'b0, idle_cnt};
                res.r0    = idle_res;
                mode_next = idle_mode;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            pv_reg   <= '0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            pv_reg   <= pv_next;
        end
    end

    always_comb
    begin
        po     = res;
        po.cnt = accept ? res.cnt : 2'd0;
    end

    `ESX_ASSERT(a_drop_silent, clk, rst_n,
        (accept && mode_reg == MODE_DROP) |-> (po.cnt == 2'd0),
        "dropped character produced a result")
    `ESX_ASSERT(a_drop_ends, clk, rst_n,
        (accept && mode_reg == MODE_DROP && last_char) |=> (mode_reg == MODE_IDLE),
        "drop mode did not end on last character")
    `ESX_ASSERT(a_err_alone, clk, rst_n,
        (po.cnt != 2'd0 && po.r0.error_code != ERR_NONE)
            |-> (po.cnt == 2'd1 && po.r0.string_done && po.r0.out_byte == 8'h00),
        "error result not alone or not ending the string")
    // state is cleared asynchronously while reset is low
    `ESX_ASSERT_ALWAYS(a_rst_idle, clk,
        !rst_n |=> (mode_reg == MODE_IDLE && pv_reg == 9'd0),
        "parser state not cleared in reset")

endmodule

`default_nettype wire

// ===== rtl/esx_out_queue.sv =====
// ----------------------------------------------------------------------------
// esx_out_queue
// three-entry result queue, takes up to two results per cycle, gives one
// ----------------------------------------------------------------------------
`default_nettype none

module esx_out_queue
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire esx_pkg::parse_out_t push,
    input  wire logic                pop,
    output esx_pkg::result_t         head,
    output logic                     not_empty,
    output logic                     room
);
    import esx_pkg::*;

    result_t    mem [3];
    logic [1:0] wr_reg;
    logic [1:0] wr_next;
    logic [1:0] rd_reg;
    logic [1:0] rd_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic [1:0] wr_plus1;

    function automatic logic [1:0] inc3(input logic [1:0] p);
        return (p == 2'd2) ? 2'd0 : p + 2'd1;
    endfunction

    assign wr_plus1 = inc3(wr_reg);

    always_comb
    begin
        wr_next    = (push.cnt == 2'd2) ? inc3(wr_plus1) :
                     (push.cnt == 2'd1) ? wr_plus1 : wr_reg;
        rd_next    = pop ? inc3(rd_reg) : rd_reg;
        count_next = 2'(3'({1'b0, count_reg}) + 3'({1'b0, push.cnt}) - 3'({2'b0, pop}));
    end

    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
            mem[wr_reg] <= push.r0;
        if (push.cnt == 2'd2)
            mem[wr_plus1] <= push.r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    assign head      = mem[rd_reg];
    assign not_empty = (count_reg != 2'd0);
    // room for a worst-case pair of results
    assign room      = (count_reg <= 2'd1);

endmodule

`default_nettype wire

// ===== rtl/escape_sequence_expander_core.sv =====
// ----------------------------------------------------------------------------
// escape_sequence_expander_core
// expands c-style escape sequences in a character stream
// ----------------------------------------------------------------------------
//  channel   dir  tdata           tuser         tlast
//  s_*       in   char_in[7:0]    -             last_char
//  m_*       out  out_byte[7:0]   error_code    string_done
//
//  one character per cycle while s_tready is high; results are registered
//  in the result queue; a character that yields two results (short hex or
//  octal run) drops s_tready while the three-entry result queue drains
//  s_tready depends only on the queue fill, never on m_tready
//  asynchronous reset returns the parser to idle and empties the queue
// ----------------------------------------------------------------------------
`default_nettype none

module escape_sequence_expander_core
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_in
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] out_byte
    output logic [2:0]       m_tuser,   // [2:0] error_code
    output logic             m_tlast
);
    import esx_pkg::*;

    logic       accept;
    logic       pop;
    parse_out_t po;
    result_t    head;
    logic       room;

    assign accept = s_tvalid && s_tready;
    assign pop    = m_tvalid && m_tready;

    esx_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .char_in   (s_tdata),
        .last_char (s_tlast),
        .po        (po)
    );

    esx_out_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (po),
        .pop       (pop),
        .head      (head),
        .not_empty (m_tvalid),
        .room      (room)
    );

    assign s_tready = room;
    assign m_tdata  = head.out_byte;
    assign m_tuser  = head.error_code;
    assign m_tlast  = head.string_done;

endmodule

`default_nettype wire
